// ===== design/rle_pkg.sv =====
// Shared types and constants of the run-mark encoder.
`default_nettype none
package rle_pkg;

   localparam int QueueDepth = 2;
   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] RunMarkReset = 8'd144;
   localparam logic [7:0] MaxRunReset = 8'd254;

   localparam logic IdxRunMark = 1'b0;
   localparam logic IdxMaxRun = 1'b1;

   typedef struct packed {
      logic [7:0] a_byte;
      logic [7:0] a_count;
      logic       has_b;
      logic [7:0] b_byte;
      logic [7:0] b_count;
      logic       end_flag;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/rle_front.sv =====
// Front end: holds the current run and turns each accepted byte into run commands.
`default_nettype none
module rle_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             end_of_input,
   input  wire logic [7:0]       run_mark,
   input  wire logic [7:0]       max_run,
   output logic                  cmd_valid,
   output rle_pkg::cmd_type      cmd
);

   logic [7:0] held_ff, held_in;
   logic [7:0] count_ff, count_in;
   logic       holding_ff, holding_in;

   logic       step_emit;
   logic [7:0] nh;
   logic [7:0] nc;
   logic       nhold;

   always_comb begin
      step_emit = 1'b0;
      nh = held_ff;
      nc = count_ff;
      nhold = holding_ff;
      if (!holding_ff) begin
         nh = in_byte;
         nc = 8'd1;
         nhold = 1'b1;
      end else if (held_ff == run_mark) begin
         step_emit = 1'b1;
         nh = in_byte;
         nc = 8'd1;
      end else if (in_byte == held_ff && count_ff < max_run) begin
         nc = count_ff + 8'd1;
      end else begin
         step_emit = 1'b1;
         nh = in_byte;
         nc = 8'd1;
      end

      cmd.end_flag = end_of_input;
      if (step_emit) begin
         cmd.a_byte = held_ff;
         cmd.a_count = count_ff;
         cmd.has_b = end_of_input;
         cmd.b_byte = nh;
         cmd.b_count = nc;
      end else begin
         cmd.a_byte = nh;
         cmd.a_count = nc;
         cmd.has_b = 1'b0;
         cmd.b_byte = nh;
         cmd.b_count = nc;
      end
      cmd_valid = accept && (step_emit || end_of_input);

      held_in = held_ff;
      count_in = count_ff;
      holding_in = holding_ff;
      if (accept) begin
         if (end_of_input) begin
            held_in = 8'd0;
            count_in = 8'd0;
            holding_in = 1'b0;
         end else begin
            held_in = nh;
            count_in = nc;
            holding_in = nhold;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'd0;
         count_ff <= 8'd0;
         holding_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         count_ff <= count_in;
         holding_ff <= holding_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/rle_queue.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none
module rle_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire rle_pkg::cmd_type push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  valid,
   output rle_pkg::cmd_type      head
);

   rle_pkg::cmd_type entries_ff [rle_pkg::QueueDepth];
   logic [rle_pkg::PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rle_pkg::PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rle_pkg::CountWidth-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   localparam logic [rle_pkg::PtrWidth-1:0] LastPtr =
      rle_pkg::PtrWidth'(rle_pkg::QueueDepth - 1);
   localparam logic [rle_pkg::CountWidth-1:0] FullCount =
      rle_pkg::CountWidth'(rle_pkg::QueueDepth);

   always_comb begin
      full = (count_ff == FullCount);
      valid = (count_ff != '0);
      head = entries_ff[rd_ptr_ff];
      do_push = push_valid && !full;
      do_pop = pop && valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/rle_back.sv =====
// Back end: expands queued run commands into packed bytes, one word per cycle while the receiver takes them.
`default_nettype none
module rle_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       run_mark,
   input  wire logic             q_valid,
   input  wire rle_pkg::cmd_type q_head,
   output logic                  q_pop,
   input  wire logic             pop,
   output logic                  empty,
   output logic [7:0]            out_byte,
   output logic                  last_of_item,
   output logic                  stream_done
);

   logic       phase_ff, phase_in;
   logic [1:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;

   logic [7:0] sel_byte;
   logic [7:0] sel_count;
   logic [1:0] len;
   logic [7:0] cur_byte;
   logic       last_step;
   logic       final_step;
   logic       advance;

   always_comb begin
      sel_byte = phase_ff ? q_head.b_byte : q_head.a_byte;
      sel_count = phase_ff ? q_head.b_count : q_head.a_count;
      if (sel_count > 8'd1) begin
         len = 2'd3;
         case (pos_ff)
            2'd0: cur_byte = sel_byte;
            2'd1: cur_byte = run_mark;
            default: cur_byte = sel_count;
         endcase
      end else if (sel_byte == run_mark) begin
         len = 2'd2;
         cur_byte = (pos_ff == 2'd0) ? run_mark : 8'd0;
      end else begin
         len = 2'd1;
         cur_byte = sel_byte;
      end
      last_step = (pos_ff == len - 2'd1);
      final_step = last_step && (phase_ff || !q_head.has_b);
      advance = q_valid && (!out_valid_ff || pop);
      q_pop = advance && final_step;

      phase_in = phase_ff;
      pos_in = pos_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_done_in = out_done_ff;
      out_valid_in = out_valid_ff && !pop;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in = cur_byte;
         out_last_in = final_step;
         out_done_in = final_step && q_head.end_flag;
         if (final_step) begin
            phase_in = 1'b0;
            pos_in = 2'd0;
         end else if (last_step) begin
            phase_in = 1'b1;
            pos_in = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end

      empty = !out_valid_ff;
      out_byte = out_byte_ff;
      last_of_item = out_last_ff;
      stream_done = out_done_ff;
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
      if (reset) begin
         phase_ff <= 1'b0;
         pos_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/rle_run_mark_encoder.sv =====
// Top level of the run-mark encoder: register port, front end, command queue, back end.
//
// Usage. Raw bytes enter on the req_ channel as a queue write: a word is taken
// at a clock edge where push is high and full is low. Packed bytes leave on the
// rsp_ channel as a queue read: the oldest byte is shown while empty is low and
// is taken at an edge where pop is high. rsp_last_of_item marks the last byte
// caused by one input word, and rsp_stream_done the last byte of the flush that
// an input flagged end_of_input causes.
// The bytes caused by a word pass through the command queue and the registered
// output of the back end before they are shown. Throughput: the back end sends
// one byte per cycle while the receiver takes them. The front end takes a word
// in every cycle while the two-entry command queue has room, also while a byte
// waits on the output.
// When the receiver stalls, the shown byte holds, the queue fills and full rises.
// Reset clears the held run, the queue and the output, and sets run_mark to 144
// and max_run to 254. Registers are written at byte addresses 0 and 4.
`default_nettype none
module rle_run_mark_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_input,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_item,
   output logic             rsp_stream_done,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0] run_mark_ff, run_mark_in;
   logic [7:0] max_run_ff, max_run_in;
   logic       reg_write;
   logic       accept;
   logic       cmd_valid;
   logic       q_full;
   logic       q_valid;
   logic       q_pop;
   rle_pkg::cmd_type cmd;
   rle_pkg::cmd_type q_head;

   always_comb begin
      pready = 1'b1;
      reg_write = psel && penable && pwrite && pready;
      run_mark_in = run_mark_ff;
      max_run_in = max_run_ff;
      if (reg_write) begin
         unique case (paddr[2])
            rle_pkg::IdxRunMark: run_mark_in = pwdata[7:0];
            rle_pkg::IdxMaxRun: max_run_in = pwdata[7:0];
            default: ;
         endcase
      end
      unique case (paddr[2])
         rle_pkg::IdxRunMark: prdata = {24'd0, run_mark_ff};
         rle_pkg::IdxMaxRun: prdata = {24'd0, max_run_ff};
         default: prdata = 32'd0;
      endcase
      full = q_full;
      accept = push && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_mark_ff <= rle_pkg::RunMarkReset;
         max_run_ff <= rle_pkg::MaxRunReset;
      end else begin
         run_mark_ff <= run_mark_in;
         max_run_ff <= max_run_in;
      end
   end

   rle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .run_mark     (run_mark_ff),
      .max_run      (max_run_ff),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd)
   );

   rle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_data  (cmd),
      .pop        (q_pop),
      .full       (q_full),
      .valid      (q_valid),
      .head       (q_head)
   );

   rle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .run_mark     (run_mark_ff),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .out_byte     (rsp_out_byte),
      .last_of_item (rsp_last_of_item),
      .stream_done  (rsp_stream_done)
   );

endmodule
`default_nettype wire

// ===== design/rle_checker.sv =====
// Port-level assertions for the run-mark encoder, bound to its top level.
`default_nettype none
module rle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last_of_item,
   input wire logic        rsp_stream_done,
   input wire logic        psel,
   input wire logic        penable,
   input wire logic        pready
);

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_stream_done) |-> rsp_last_of_item)
      else $error("stream end shown on a word that does not end its item");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("output not empty after reset");

   a_not_full_after_reset: assert property (@(posedge clock)
      reset |=> !full)
      else $error("input full after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte)
         && $stable(rsp_last_of_item) && $stable(rsp_stream_done)))
      else $error("stalled output word changed");

   a_ready_high: assert property (@(posedge clock) disable iff (reset)
      (psel && penable) |-> pready)
      else $error("register access not ready");

endmodule

bind rle_run_mark_encoder rle_checker u_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the run-mark encoder: queued stimulus, predictor and word checker.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LimitCycles = 400000;
   localparam int SettleCycles = 12;
   localparam int IdlePercent = 36;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       final_flag;
   } raw_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       stream_done;
   } packed_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_end_of_input = 1'b0;
   logic        pop = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   wire         full;
   wire         empty;
   wire  [7:0]  rsp_out_byte;
   wire         rsp_last_of_item;
   wire         rsp_stream_done;
   wire  [31:0] prdata;
   wire         pready;

   raw_word_type    raw_words_q[$];
   packed_word_type packed_words_q[$];
   logic [7:0]      step_bytes[$];
   int              mismatch_count = 0;
   logic            no_idle = 1'b0;

   // Mirror of the encoder state and its registers.
   logic [7:0] mark_reg = rle_pkg::RunMarkReset;
   logic [7:0] limit_reg = rle_pkg::MaxRunReset;
   logic [7:0] held_byte = 8'h00;
   logic [7:0] run_len = 8'h00;
   logic       holding = 1'b0;

   rle_run_mark_encoder dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_byte(req_in_byte),
      .req_end_of_input(req_end_of_input),
      .empty(empty),
      .pop(pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_stream_done(rsp_stream_done),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #4 clock = ~clock;

   function automatic void pack_run(input logic [7:0] b, input logic [7:0] cnt);
      if (cnt > 8'd1) begin
         step_bytes.push_back(b);
         step_bytes.push_back(mark_reg);
         step_bytes.push_back(cnt);
      end else if (b == mark_reg) begin
         step_bytes.push_back(mark_reg);
         step_bytes.push_back(8'h00);
      end else begin
         step_bytes.push_back(b);
      end
   endfunction

   function automatic void predict_packing(input logic [7:0] b, input logic fin);
      packed_word_type w;
      step_bytes.delete();
      if (!holding) begin
         held_byte = b;
         run_len = 8'd1;
         holding = 1'b1;
      end else if (held_byte == mark_reg) begin
         pack_run(held_byte, run_len);
         held_byte = b;
         run_len = 8'd1;
      end else if (b == held_byte && run_len < limit_reg) begin
         run_len = run_len + 8'd1;
      end else begin
         pack_run(held_byte, run_len);
         held_byte = b;
         run_len = 8'd1;
      end
      if (fin) begin
         pack_run(held_byte, run_len);
         held_byte = 8'h00;
         run_len = 8'h00;
         holding = 1'b0;
      end
      foreach (step_bytes[i]) begin
         w.out_byte = step_bytes[i];
         w.last_of_item = (i == step_bytes.size() - 1);
         w.stream_done = fin && (i == step_bytes.size() - 1);
         packed_words_q.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      raw_word_type w;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            predict_packing(req_in_byte, req_end_of_input);
         end
         if (push && full) begin
            push <= 1'b1;
         end else if (raw_words_q.size() != 0
                      && (no_idle || $urandom_range(99) >= IdlePercent)) begin
            w = raw_words_q.pop_front();
            push <= 1'b1;
            req_in_byte <= w.raw_byte;
            req_end_of_input <= w.final_flag;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      packed_word_type got;
      packed_word_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got = '{rsp_out_byte, rsp_last_of_item, rsp_stream_done};
            if (packed_words_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected word: byte %h last %b done %b",
                           got.out_byte, got.last_of_item, got.stream_done);
            end else begin
               want = packed_words_q.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Mismatch: expected byte %h last %b done %b, ",
                               "got byte %h last %b done %b"},
                              want.out_byte, want.last_of_item, want.stream_done,
                              got.out_byte, got.last_of_item, got.stream_done);
               end
            end
         end
         pop <= no_idle || ($urandom_range(99) >= IdlePercent);
      end
   end

   task automatic csr_write(input logic idx, input logic [7:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {8'($urandom_range(255)), 16'h0000, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      if (idx == rle_pkg::IdxRunMark)
         mark_reg = val;
      else
         limit_reg = val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[7:0] !== val) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Register %0d read back %h, expected %h", idx, prdata[7:0], val);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic add_word(input logic [7:0] b, input logic fin);
      raw_words_q.push_back('{b, fin});
   endtask

   task automatic wait_idle();
      while (raw_words_q.size() != 0 || push || packed_words_q.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Runs of random length of the run mark, 00, FF, the previous byte or a random byte.
   task automatic add_streams(input int n_words);
      int added;
      int len;
      logic [7:0] b;
      logic [7:0] prev;
      added = 0;
      prev = 8'h00;
      while (added < n_words) begin
         case ($urandom_range(9))
            0, 1: b = mark_reg;
            2: b = 8'h00;
            3: b = 8'hFF;
            4: b = prev;
            default: b = 8'($urandom_range(255));
         endcase
         if ($urandom_range(7) == 0 && limit_reg <= 8'd16)
            len = int'(limit_reg) + int'($urandom_range(2));
         else
            len = int'($urandom_range(1, 4));
         for (int i = 0; i < len; i++)
            add_word(b, (i == len - 1) && ($urandom_range(5) == 0));
         prev = b;
         added += len;
      end
   endtask

   initial begin
      repeat (LimitCycles) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [7:0] mark_val;
      logic [7:0] limit_val;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_word(8'h00, 1'b1);
      add_word(8'hFF, 1'b0);
      add_word(8'hFF, 1'b0);
      add_word(8'hFF, 1'b1);
      add_word(8'h90, 1'b0);
      add_word(8'h90, 1'b0);
      add_word(8'h90, 1'b1);
      add_word(8'h55, 1'b0);
      add_word(8'hAA, 1'b1);
      add_word(8'h33, 1'b0);
      add_word(8'h33, 1'b0);
      add_word(8'h33, 1'b0);
      wait_idle();
      // The held run now matches the new run mark.
      csr_write(rle_pkg::IdxRunMark, 8'h33);
      add_word(8'h33, 1'b1);
      repeat (4) add_word(8'h05, 1'b0);
      wait_idle();
      // A lower limit ends the held run at the next byte.
      csr_write(rle_pkg::IdxMaxRun, 8'd2);
      add_word(8'h05, 1'b1);
      wait_idle();
      csr_write(rle_pkg::IdxMaxRun, 8'd1);
      csr_write(rle_pkg::IdxRunMark, 8'h00);
      add_word(8'h07, 1'b0);
      add_word(8'h07, 1'b0);
      add_word(8'h07, 1'b1);
      wait_idle();
      csr_write(rle_pkg::IdxMaxRun, 8'd0);
      add_word(8'h07, 1'b0);
      add_word(8'h07, 1'b1);
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         case ($urandom_range(3))
            0: mark_val = 8'h00;
            1: mark_val = 8'hFF;
            default: mark_val = 8'($urandom_range(255));
         endcase
         case ($urandom_range(3))
            0: limit_val = 8'd2;
            1: limit_val = 8'd255;
            2: limit_val = 8'($urandom_range(2, 8));
            default: limit_val = 8'($urandom_range(2, 255));
         endcase
         if (p == 0 || $urandom_range(1) == 0)
            csr_write(rle_pkg::IdxRunMark, mark_val);
         csr_write(rle_pkg::IdxMaxRun, limit_val);
         add_streams(22);
         repeat (4) add_word(8'($urandom_range(255)), $urandom_range(19) == 0);
         wait_idle();
      end

      csr_write(rle_pkg::IdxMaxRun, 8'd255);
      csr_write(rle_pkg::IdxRunMark, 8'hC3);
      no_idle = 1'b1;
      for (int i = 0; i < 257; i++)
         add_word(8'h3C, i == 256);
      wait_idle();
      no_idle = 1'b0;
      csr_write(rle_pkg::IdxMaxRun, rle_pkg::MaxRunReset);
      add_streams(20);
      add_word(8'h81, 1'b1);
      wait_idle();
      repeat (SettleCycles) @(posedge clock);

      if (mismatch_count == 0 && packed_words_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
design/rle_pkg.sv
design/rle_front.sv
design/rle_queue.sv
design/rle_back.sv
design/rle_run_mark_encoder.sv
design/rle_checker.sv
tb/testbench.sv
